[hw/rtl/pvi_pkg.sv]
// Package for the positive volume index core: field widths, fixed-point
// layout and reset constants. No dependencies.
`default_nettype none

package pvi_pkg;

  localparam int unsigned CloseW     = 32;  // close price, unsigned Q16.16
  localparam int unsigned VolW       = 40;  // bar volume, unsigned integer
  localparam int unsigned IdxW       = 48;  // index, unsigned Q32.16
  localparam int unsigned RatioFracW = 24;  // fraction bits of the price ratio

  // Ratio magnitude = (diff << RatioFracW) / last_close
  localparam int unsigned DivDendW = CloseW + RatioFracW;
  localparam int unsigned QuotW    = DivDendW;
  localparam int unsigned DivCntW  = $clog2(QuotW);

  // Shift-add multiplier: ratio (zero padded) taken in 16-bit chunks, MSB first
  localparam int unsigned ChunkW    = 16;
  localparam int unsigned NumChunks = (QuotW + ChunkW - 1) / ChunkW;
  localparam int unsigned MagPadW   = NumChunks * ChunkW;
  localparam int unsigned ChunkSelW = $clog2(NumChunks);
  localparam int unsigned PpW       = ChunkW + IdxW;
  localparam int unsigned AccW      = QuotW + IdxW;
  localparam int unsigned DeltaW    = AccW - RatioFracW;
  localparam int unsigned MulStepW  = $clog2(NumChunks + 1);

  localparam logic [IdxW-1:0] SeedReset = IdxW'(65536000);  // 1000.0 in Q32.16

endpackage : pvi_pkg

`default_nettype wire

[hw/rtl/positive_volume_index_core.sv]
// Positive volume index core. Top level; uses pvi_pkg and pvi_div.
// One bar in, one index value out.
`default_nettype none

// Takes one bar per transfer (close price Q16.16, volume, series start flag)
// and returns one transfer holding the running index in Q32.16 plus a hold
// flag. A bar that starts a series, or the first bar after reset, reloads the
// index from the seed register. On later bars the index moves only when the
// volume rose and the previous close is nonzero: the relative change is
// formed with 24 fraction bits and applied to the index, both truncated. A
// rise that would leave the 48-bit range keeps the old index and sets
// overflow_held_o. The block holds one bar at a time; in_stall_o is high from
// the accepting edge until the result is loaded into the output register.
// Bars that skip the update (series start, first bar, volume not higher,
// previous close zero) go from the accepting edge straight to S_FIN, which
// loads the output register. Updating bars go from the accepting edge
// through the restoring divider (one quotient bit per cycle, 56-bit
// quotient), taking the quotient, the 16x48 shift-add multiply over four
// 16-bit ratio chunks, the index update and the output register load. A
// result still held by out_stall_i delays that last load. The output
// register lets the next bar enter while the previous result still waits on
// out_stall_i.
// The seed register seed_q is written through cfg_we_i/cfg_wdata_i and takes
// effect at the next series start or first bar after reset.

module positive_volume_index_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [pvi_pkg::IdxW-1:0]       cfg_wdata_i,
  // bar input
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pvi_pkg::CloseW-1:0]     close_price_i,
  input  wire logic [pvi_pkg::VolW-1:0]       bar_volume_i,
  input  wire logic                           series_start_i,
  // index output
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [pvi_pkg::IdxW-1:0]       index_value_o,
  output logic                                overflow_held_o
);
  import pvi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_UPD,
    S_FIN
  } state_e;

  state_e               state_q;
  logic [IdxW-1:0]      seed_q;
  logic [CloseW-1:0]    last_close_q;
  logic [VolW-1:0]      last_vol_q;
  logic [IdxW-1:0]      idx_q;
  logic                 have_prev_q;
  logic                 rise_q;
  logic                 held_q;
  logic [QuotW-1:0]     mag_q;
  logic [MulStepW-1:0]  mul_step_q;
  logic [PpW-1:0]       pp_q;
  logic [AccW-1:0]      acc_q;
  logic                 out_valid_q;
  logic [IdxW-1:0]      out_idx_q;
  logic                 out_held_q;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 reseed;
  logic                 do_update;
  logic                 rise;
  logic [CloseW-1:0]    diff;
  logic                 div_done;
  logic [QuotW-1:0]     div_quot;
  logic [MagPadW-1:0]   mag_pad;
  logic [ChunkSelW-1:0] chunk_sel;
  logic [ChunkW-1:0]    chunk;
  logic [PpW-1:0]       pp;
  logic [DeltaW-1:0]    delta;
  logic [IdxW:0]        sum;
  logic                 ovf;
  logic                 out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Bar classification at accept time, against the previous bar's state
  assign reseed    = series_start_i || !have_prev_q;
  assign do_update = !reseed && (bar_volume_i > last_vol_q) && (last_close_q != '0);
  assign rise      = close_price_i >= last_close_q;
  assign diff      = rise ? close_price_i - last_close_q : last_close_q - close_price_i;

  pvi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer && do_update),
    .dividend_i ({diff, RatioFracW'(0)}),
    .divisor_i  (last_close_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Multiply chunk: most significant chunk first, so step k takes chunk (last - k)
  assign mag_pad   = MagPadW'(mag_q);
  assign chunk_sel = ChunkSelW'(NumChunks - 1) - mul_step_q[ChunkSelW-1:0];
  assign chunk     = mag_pad[chunk_sel*ChunkW +: ChunkW];
  assign pp        = PpW'(chunk) * PpW'(idx_q);

  // Update: delta = (mag * idx) >> 24
  assign delta = acc_q[AccW-1:RatioFracW];
  assign sum   = {1'b0, idx_q} + (IdxW+1)'(delta[IdxW-1:0]);
  assign ovf   = (delta[DeltaW-1:IdxW] != '0) || sum[IdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      seed_q       <= SeedReset;
      last_close_q <= '0;
      last_vol_q   <= '0;
      idx_q        <= SeedReset;
      have_prev_q  <= 1'b0;
      rise_q       <= 1'b0;
      held_q       <= 1'b0;
      mag_q        <= '0;
      mul_step_q   <= '0;
      pp_q         <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_held_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      // in S_FIN a drained output register is refilled below
      if (out_xfer && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            last_close_q <= close_price_i;
            last_vol_q   <= bar_volume_i;
            rise_q       <= rise;
            held_q       <= 1'b0;
            have_prev_q  <= 1'b1;
            if (reseed) begin
              idx_q <= seed_q;
            end
            state_q <= do_update ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mag_q      <= div_quot;
            mul_step_q <= '0;
            acc_q      <= '0;
            state_q    <= S_MUL;
          end
        end
        S_MUL: begin
          // steps 0..N-1 form partial products, steps 1..N accumulate them
          if (mul_step_q != MulStepW'(NumChunks)) begin
            pp_q <= pp;
          end
          if (mul_step_q != '0) begin
            acc_q <= (acc_q << ChunkW) + AccW'(pp_q);
          end
          if (mul_step_q == MulStepW'(NumChunks)) begin
            state_q <= S_UPD;
          end
          mul_step_q <= mul_step_q + 1'b1;
        end
        S_UPD: begin
          if (rise_q) begin
            if (ovf) begin
              held_q <= 1'b1;
            end else begin
              idx_q <= sum[IdxW-1:0];
            end
          end else begin
            // a fall never exceeds the index, clamp kept for safety
            if (delta > DeltaW'(idx_q)) begin
              idx_q <= '0;
            end else begin
              idx_q <= idx_q - delta[IdxW-1:0];
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= idx_q;
            out_held_q  <= held_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign index_value_o   = out_idx_q;
  assign overflow_held_o = out_held_q;

endmodule : positive_volume_index_core

`default_nettype wire

[hw/rtl/pvi_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on pvi_pkg for operand widths.
`default_nettype none

module pvi_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [pvi_pkg::DivDendW-1:0]   dividend_i,
  input  wire logic [pvi_pkg::CloseW-1:0]     divisor_i,
  output logic                                done_o,
  output logic      [pvi_pkg::QuotW-1:0]      quot_o
);
  import pvi_pkg::*;

  logic [DivDendW-1:0] dq_q;     // dividend bits shift out, quotient bits shift in
  logic [CloseW-1:0]   rem_q;
  logic [CloseW-1:0]   dvs_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [CloseW:0]     rem_sh;
  logic [CloseW:0]     trial;
  logic                qbit;

  assign rem_sh = {rem_q, dq_q[DivDendW-1]};
  assign trial  = rem_sh - {1'b0, dvs_q};
  assign qbit   = ~trial[CloseW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(QuotW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DivDendW-2:0], qbit};
      rem_q <= qbit ? trial[CloseW-1:0] : rem_sh[CloseW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule : pvi_div

`default_nettype wire
